>>> rtl/tbce_pkg.sv
// Shared types and constants for the per-bit line word change detector.
`default_nettype none
package tbce_pkg;

    // Number of streams that keep a previous word.
    localparam int unsigned NUM_STREAMS = 8;

    // Field widths.
    localparam int unsigned STREAM_W = 3;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned SAMPLE_W = 63;
    localparam int unsigned BIT_W    = 6;
    localparam int unsigned COUNT_W  = 7;

    // Bit count after reset: all bits of the word generate events.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_FULL  = 7'd64;

    // One input sample.
    typedef struct packed {
        logic [STREAM_W-1:0] stream_index;
        logic [WORD_W-1:0]   line_word;
        logic [SAMPLE_W-1:0] sample_number;
    } t_in_item;

    // One change event.
    typedef struct packed {
        logic [STREAM_W-1:0] event_stream;
        logic [SAMPLE_W-1:0] event_sample;
        logic [BIT_W-1:0]    bit_index;
        logic                bit_level;
        logic [WORD_W-1:0]   full_word;
        logic                last_event;
    } t_out_item;

    // Sample with its mask of bits that still have to produce events.
    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [SAMPLE_W-1:0] sample;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   mask;
    } t_work;

endpackage : tbce_pkg
`default_nettype wire

>>> rtl/tbce_detect.sv
// Previous word store per stream and changed-bit mask computation.
`default_nettype none
module tbce_detect (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire tbce_pkg::t_in_item      i_item,
    input  wire logic [tbce_pkg::COUNT_W-1:0] i_bit_count,
    output tbce_pkg::t_work              o_work
);
    import tbce_pkg::*;

    logic [WORD_W-1:0] r_prev [NUM_STREAMS];
    logic [WORD_W-1:0] limit_mask;
    logic [WORD_W-1:0] changed;
    logic              stream_ok;

    // Streams beyond the configured count are ignored entirely.
    assign stream_ok = (32'(i_item.stream_index) < NUM_STREAMS);

    // Mask of the low bits that are allowed to produce events.
    assign limit_mask = (i_bit_count >= COUNT_FULL) ? {WORD_W{1'b1}}
                      : ~({WORD_W{1'b1}} << i_bit_count[BIT_W-1:0]);

    assign changed = i_item.line_word ^ r_prev[i_item.stream_index];

    // Work item for the event emitter.
    always_comb begin
        o_work.stream = i_item.stream_index;
        o_work.sample = i_item.sample_number;
        o_work.word   = i_item.line_word;
        o_work.mask   = stream_ok ? (changed & limit_mask) : '0;
    end

    // The new word always replaces the stream's previous word on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STREAMS; s++) begin
                r_prev[s] <= '0;
            end
        end else if (i_accept && stream_ok) begin
            r_prev[i_item.stream_index] <= i_item.line_word;
        end
    end

endmodule : tbce_detect
`default_nettype wire

>>> rtl/tbce_emit.sv
// Work register and output register that issue one change event per cycle while the output is not stalled.
`default_nettype none
module tbce_emit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire tbce_pkg::t_work         i_work,
    output logic                         o_busy,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output tbce_pkg::t_out_item          o_out_item
);
    import tbce_pkg::*;

    logic              r_w_valid;
    t_work             r_w;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [WORD_W-1:0] low_bit;
    logic [WORD_W-1:0] rest;
    logic [BIT_W-1:0]  low_idx;
    logic              out_load;
    logic              issue;
    logic              w_done;
    logic              accept;

    // Lowest pending bit and the mask that remains after it.
    assign low_bit = r_w.mask & (~r_w.mask + 64'd1);
    assign rest    = r_w.mask & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (low_bit[b]) begin
                low_idx = low_idx | BIT_W'(b);
            end
        end
    end

    // Handshake: the output register loads when empty or being taken.
    assign out_load = !r_out_valid || !i_out_stall;
    assign issue    = r_w_valid && out_load;
    assign w_done   = issue && (rest == '0);
    assign o_busy   = r_w_valid && !w_done;
    assign accept   = i_in_valid && !o_busy;

    // Work register: holds a sample until all its events are issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_w_valid <= 1'b0;
            end
            if (accept) begin
                r_w_valid <= (i_work.mask != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w <= i_work;
        end else if (issue) begin
            r_w.mask <= rest;
        end
    end

    // Output register for one event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out.event_stream <= r_w.stream;
            r_out.event_sample <= r_w.sample;
            r_out.bit_index    <= low_idx;
            r_out.bit_level    <= r_w.word[low_idx];
            r_out.full_word    <= r_w.word;
            r_out.last_event   <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule : tbce_emit
`default_nettype wire

>>> rtl/ttl_word_bit_change_events_top.sv
// Top level of the per-bit line word change event generator.
//
// Input channel: one transfer carries a stream index, a 64-bit line word and
// its sample number. The word is compared with the stream's previous word,
// and the new word is stored at the transfer edge, so a sample of the same
// stream may follow in the very next cycle.
// Output channel: one transfer per event, lowest changed bit first, with the
// final event of a sample flagged as last. Only bits below the configured
// bit count produce events.
// Flow: the first event of a sample passes through the work register and then
// the output register before it is presented. A sample with no events never
// stalls the input, and neither does one with a single event while the output
// is not stalled; a sample with more events occupies the work register until
// its last event issues, one event per cycle while the output is not stalled.
// When the receiver stalls, the output register holds its event and the
// input channel stalls once the work register cannot drain.
// Configuration: the bit count register accepts a write in any cycle and
// should be written only while the block is idle.
// Reset: all previous words clear to zero, the bit count returns to 64 and
// both channels are empty.
`default_nettype none
module ttl_word_bit_change_events_top (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire tbce_pkg::t_in_item      i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output tbce_pkg::t_out_item          o_out_item,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [tbce_pkg::COUNT_W-1:0] i_cfg_data
);
    import tbce_pkg::*;

    logic [COUNT_W-1:0] r_bit_count;
    logic               busy;
    logic               in_accept;
    t_work              work;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bit_count <= i_cfg_data;
        end
    end

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    tbce_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .i_bit_count (r_bit_count),
        .o_work      (work)
    );

    tbce_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_work      (work),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule : ttl_word_bit_change_events_top
`default_nettype wire
